// ----- design/gmss_pkg.sv -----
// Shared types, codes and constants for the gate motor soft-start controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gmss_pkg;

  localparam int unsigned WINDOW_LEN_DEF  = 6;
  localparam int unsigned SAMPLE_W        = 10;
  localparam int unsigned DUTY_W          = 8;
  localparam int unsigned MS_W            = 16;
  localparam int unsigned DELAY_W         = 7;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam int unsigned RELAY_TICKS     = 4;
  localparam int unsigned WAIT_TICKS      = 100;
  localparam int unsigned TICK_MS         = 10;
  localparam int unsigned SAMPLE_AFTER_MS = 2000;
  localparam int unsigned TRIP_COUNT      = 4;
  localparam int unsigned SLOW_STEP       = 2;
  localparam int unsigned STOP_STEP       = 3;

  localparam logic [DUTY_W-1:0]   START_DUTY_RST = 8'd50;
  localparam logic [DUTY_W-1:0]   FULL_DUTY_RST  = 8'd255;
  localparam logic [DUTY_W-1:0]   CREEP_DUTY_RST = 8'd100;
  localparam logic [MS_W-1:0]     SLOWDOWN_RST   = 16'd10000;
  localparam logic [MS_W-1:0]     RUN_LIMIT_RST  = 16'd30000;
  localparam logic [SAMPLE_W-1:0] TRIP_LEVEL_RST = 10'd80;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_START  = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    PH_STOP   = 4'd0,
    PH_INIT   = 4'd1,
    PH_RELAY  = 4'd2,
    PH_RAMP   = 4'd3,
    PH_RUN    = 4'd4,
    PH_SLOW   = 4'd5,
    PH_LOW    = 4'd6,
    PH_TOZERO = 4'd7,
    PH_WAIT   = 4'd8,
    PH_END    = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    POS_UNKNOWN = 2'd0,
    AT_OPEN     = 2'd1,
    AT_CLOSED   = 2'd2
  } pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_DUTY = 3'd0,
    CFG_FULL_DUTY  = 3'd1,
    CFG_CREEP_DUTY = 3'd2,
    CFG_SLOWDOWN   = 3'd3,
    CFG_RUN_LIMIT  = 3'd4,
    CFG_TRIP_LEVEL = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   start_duty;
    logic [DUTY_W-1:0]   full_duty;
    logic [DUTY_W-1:0]   creep_duty;
    logic [MS_W-1:0]     slowdown_after_ms;
    logic [MS_W-1:0]     run_limit_ms;
    logic [SAMPLE_W-1:0] trip_level;
  } cfg_t;

  typedef struct packed {
    logic              timed_out;
    logic              tripped;
    logic              finished;
    logic [1:0]        position;
    logic              running;
    logic [3:0]        phase;
    logic [DUTY_W-1:0] pwm_duty;
  } res_t;

endpackage

`default_nettype wire

// ----- design/gmss_ring.sv -----
// Current sample window: ring of recent samples and overcurrent count.
// Depends on gmss_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module gmss_ring #(
  parameter int unsigned WINDOW_LEN = gmss_pkg::WINDOW_LEN_DEF,
  localparam int unsigned IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1,
  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [gmss_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [gmss_pkg::SAMPLE_W-1:0] trip_level,
  output logic      [CNT_W-1:0]              over_cnt
);

  logic [gmss_pkg::SAMPLE_W-1:0] ring [WINDOW_LEN];
  logic [IDX_W-1:0]              ring_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_index <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring[i] <= '0;
      end
    end else if (wr_en) begin
      ring[ring_index] <= sample;
      if (ring_index == IDX_W'(WINDOW_LEN - 1)) begin
        ring_index <= '0;
      end else begin
        ring_index <= ring_index + 1'b1;
      end
    end
  end

  // count over the window as it stands once the new sample is in
  always_comb begin
    over_cnt = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (ring_index == IDX_W'(i)) begin
        if (sample > trip_level) over_cnt = over_cnt + 1'b1;
      end else if (ring[i] > trip_level) begin
        over_cnt = over_cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/gmss_seq.sv -----
// Phase sequencer: duty ramps, run time, delays and position record.
// Depends on gmss_pkg for codes, config and result types.
`timescale 1ns / 1ps
`default_nettype none

module gmss_seq #(
  parameter int unsigned WINDOW_LEN = gmss_pkg::WINDOW_LEN_DEF,
  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic [1:0]                    func,
  input  wire logic                          dir,
  input  wire gmss_pkg::cfg_t                cfg,
  input  wire logic [CNT_W-1:0]              over_cnt,
  output logic                               ring_wr,
  output gmss_pkg::res_t                     res
);

  gmss_pkg::phase_t                phase, phase_next;
  logic [gmss_pkg::DUTY_W-1:0]     duty, duty_next;
  logic [gmss_pkg::MS_W-1:0]       elapsed, elapsed_next;
  logic [gmss_pkg::DELAY_W-1:0]    delay_count, delay_count_next;
  logic                            travel_dir, travel_dir_next;
  logic [1:0]                      last_position, last_position_next;
  logic                            run_flag, run_flag_next;
  logic [gmss_pkg::MS_W:0]         el_sum;
  logic [gmss_pkg::MS_W-1:0]       el_sat;
  logic                            fin, trip, tout;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= gmss_pkg::PH_STOP;
      duty          <= '0;
      elapsed       <= '0;
      delay_count   <= '0;
      travel_dir    <= 1'b0;
      last_position <= gmss_pkg::POS_UNKNOWN;
      run_flag      <= 1'b0;
    end else begin
      phase         <= phase_next;
      duty          <= duty_next;
      elapsed       <= elapsed_next;
      delay_count   <= delay_count_next;
      travel_dir    <= travel_dir_next;
      last_position <= last_position_next;
      run_flag      <= run_flag_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    duty_next          = duty;
    elapsed_next       = elapsed;
    delay_count_next   = delay_count;
    travel_dir_next    = travel_dir;
    last_position_next = last_position;
    run_flag_next      = run_flag;
    ring_wr            = 1'b0;
    fin                = 1'b0;
    trip               = 1'b0;
    tout               = 1'b0;
    el_sum             = '0;
    el_sat             = '0;
    if (en) begin
      case (func)
        gmss_pkg::FUNC_TICK: begin
          case (phase)
            gmss_pkg::PH_INIT: begin
              elapsed_next     = '0;
              run_flag_next    = 1'b1;
              duty_next        = '0;
              delay_count_next = gmss_pkg::DELAY_W'(gmss_pkg::RELAY_TICKS);
              phase_next       = gmss_pkg::PH_RELAY;
            end
            gmss_pkg::PH_RELAY: begin
              if (delay_count != '0) begin
                delay_count_next = delay_count - 1'b1;
              end else begin
                duty_next  = cfg.start_duty;
                phase_next = gmss_pkg::PH_RAMP;
              end
            end
            gmss_pkg::PH_RAMP: begin
              if (duty < cfg.full_duty) duty_next = duty + 1'b1;
              else phase_next = gmss_pkg::PH_RUN;
            end
            gmss_pkg::PH_RUN: begin
              if (elapsed > cfg.slowdown_after_ms) phase_next = gmss_pkg::PH_SLOW;
            end
            gmss_pkg::PH_SLOW: begin
              if (duty > cfg.creep_duty) begin
                if (duty >= gmss_pkg::DUTY_W'(gmss_pkg::SLOW_STEP)) begin
                  duty_next = duty - gmss_pkg::DUTY_W'(gmss_pkg::SLOW_STEP);
                end else begin
                  duty_next = '0;
                end
              end else begin
                duty_next  = cfg.creep_duty;
                phase_next = gmss_pkg::PH_LOW;
              end
            end
            gmss_pkg::PH_TOZERO: begin
              if (duty >= gmss_pkg::DUTY_W'(gmss_pkg::STOP_STEP)) begin
                duty_next = duty - gmss_pkg::DUTY_W'(gmss_pkg::STOP_STEP);
              end else begin
                duty_next        = '0;
                delay_count_next = gmss_pkg::DELAY_W'(gmss_pkg::WAIT_TICKS);
                phase_next       = gmss_pkg::PH_WAIT;
              end
            end
            gmss_pkg::PH_WAIT: begin
              if (delay_count != '0) delay_count_next = delay_count - 1'b1;
              else phase_next = gmss_pkg::PH_END;
            end
            gmss_pkg::PH_END: begin
              run_flag_next      = 1'b0;
              phase_next         = gmss_pkg::PH_STOP;
              last_position_next = travel_dir ? gmss_pkg::AT_CLOSED : gmss_pkg::AT_OPEN;
              fin                = 1'b1;
            end
            default: begin
            end
          endcase
          // advance run time and check the limit
          if (run_flag_next) begin
            el_sum = {1'b0, elapsed_next} + (gmss_pkg::MS_W + 1)'(gmss_pkg::TICK_MS);
            el_sat = el_sum[gmss_pkg::MS_W] ? '1 : el_sum[gmss_pkg::MS_W-1:0];
            if (el_sat > cfg.run_limit_ms) begin
              elapsed_next = '0;
              phase_next   = gmss_pkg::PH_TOZERO;
              tout         = 1'b1;
            end else begin
              elapsed_next = el_sat;
            end
          end
        end
        gmss_pkg::FUNC_SAMPLE: begin
          if (elapsed > gmss_pkg::MS_W'(gmss_pkg::SAMPLE_AFTER_MS)) begin
            ring_wr = 1'b1;
            if (run_flag && 32'(over_cnt) >= gmss_pkg::TRIP_COUNT) begin
              duty_next     = '0;
              run_flag_next = 1'b0;
              phase_next    = gmss_pkg::PH_END;
              trip          = 1'b1;
            end
          end
        end
        gmss_pkg::FUNC_START: begin
          travel_dir_next = dir;
          phase_next      = gmss_pkg::PH_INIT;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.pwm_duty  = duty_next;
    res.phase     = phase_next;
    res.running   = run_flag_next;
    res.position  = last_position_next;
    res.finished  = fin;
    res.tripped   = trip;
    res.timed_out = tout;
  end

endmodule

`default_nettype wire

// ----- design/gate_motor_softstart_controller_core.sv -----
// Gate motor soft-start controller: stream in, one result per item out.
// Path: input register, then result register, so the result transaction
// always comes after the input transaction that it answers.
// Throughput: one item per cycle, back to back; a held result stalls the input.
// Reset (rst, synchronous) clears phase, duty, run time, ring and position,
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module gate_motor_softstart_controller_core #(
  parameter int unsigned WINDOW_LEN = gmss_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [15:0]                     s_axis_tdata,  // current_sample, direction
  input  wire logic [1:0]                      s_axis_tuser,  // func
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // pwm_duty, phase, running, position, finished, tripped, timed_out
  output logic [23:0]                          m_axis_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gmss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gmss_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);

  gmss_pkg::cfg_t                cfg;
  logic                          in_valid;
  logic [1:0]                    in_func;
  logic [gmss_pkg::SAMPLE_W-1:0] in_sample;
  logic                          in_dir;
  logic                          step;
  logic                          ring_wr;
  logic [CNT_W-1:0]              over_cnt;
  gmss_pkg::res_t                res;
  gmss_pkg::res_t                out_res;

  assign cfg_ready     = 1'b1;
  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;
  assign m_axis_tdata  = {6'd0, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_duty        <= gmss_pkg::START_DUTY_RST;
      cfg.full_duty         <= gmss_pkg::FULL_DUTY_RST;
      cfg.creep_duty        <= gmss_pkg::CREEP_DUTY_RST;
      cfg.slowdown_after_ms <= gmss_pkg::SLOWDOWN_RST;
      cfg.run_limit_ms      <= gmss_pkg::RUN_LIMIT_RST;
      cfg.trip_level        <= gmss_pkg::TRIP_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gmss_pkg::CFG_START_DUTY: cfg.start_duty <= cfg_data[gmss_pkg::DUTY_W-1:0];
        gmss_pkg::CFG_FULL_DUTY:  cfg.full_duty  <= cfg_data[gmss_pkg::DUTY_W-1:0];
        gmss_pkg::CFG_CREEP_DUTY: cfg.creep_duty <= cfg_data[gmss_pkg::DUTY_W-1:0];
        gmss_pkg::CFG_SLOWDOWN:   cfg.slowdown_after_ms <= cfg_data;
        gmss_pkg::CFG_RUN_LIMIT:  cfg.run_limit_ms <= cfg_data;
        gmss_pkg::CFG_TRIP_LEVEL: cfg.trip_level <= cfg_data[gmss_pkg::SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func   <= s_axis_tuser;
      in_sample <= s_axis_tdata[gmss_pkg::SAMPLE_W-1:0];
      in_dir    <= s_axis_tdata[gmss_pkg::SAMPLE_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  gmss_ring #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (ring_wr),
    .sample     (in_sample),
    .trip_level (cfg.trip_level),
    .over_cnt   (over_cnt)
  );

  gmss_seq #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .en       (step),
    .func     (in_func),
    .dir      (in_dir),
    .cfg      (cfg),
    .over_cnt (over_cnt),
    .ring_wr  (ring_wr),
    .res      (res)
  );

endmodule

`default_nettype wire

// ----- tb/sv/gate_motor_softstart_controller_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for gate_motor_softstart_controller_core: drives start, tick and current
// sample transactions, predicts every result with a behavioral sequencer and checks it.
// Depends on gmss_pkg and the controller RTL; needs no files or arguments.
module gate_motor_softstart_controller_core_tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned WPTR_W = $clog2(gmss_pkg::WINDOW_LEN_DEF);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // current_sample[9:0], direction[10], zero fill
  logic [1:0] s_axis_tuser = '0;   // func
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // pwm_duty, phase, running, position, finished, tripped, timed_out, zero fill
  logic [23:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gmss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gmss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  gate_motor_softstart_controller_core uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  gmss_pkg::cfg_t shadow_cfg;
  gmss_pkg::phase_t gate_phase;
  logic [gmss_pkg::DUTY_W-1:0] gate_duty;
  logic [gmss_pkg::MS_W-1:0] run_ms;
  logic [gmss_pkg::DELAY_W-1:0] hold_count;
  logic dir_latch;
  gmss_pkg::pos_t last_pos;
  logic motor_on;
  logic [gmss_pkg::SAMPLE_W-1:0] adc_window [gmss_pkg::WINDOW_LEN_DEF];
  logic [WPTR_W-1:0] window_ptr;

  gmss_pkg::res_t pending_results[$];
  gmss_pkg::res_t got_res;
  gmss_pkg::res_t want_res;
  int unsigned send_gap_pct;
  int unsigned sink_stall_pct;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned trips_seen = 0;
  int unsigned timeouts_seen = 0;
  int unsigned runs_finished = 0;
  int unsigned idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  function automatic void reset_gate();
    shadow_cfg = '{gmss_pkg::START_DUTY_RST, gmss_pkg::FULL_DUTY_RST,
                   gmss_pkg::CREEP_DUTY_RST, gmss_pkg::SLOWDOWN_RST,
                   gmss_pkg::RUN_LIMIT_RST, gmss_pkg::TRIP_LEVEL_RST};
    gate_phase = gmss_pkg::PH_STOP;
    gate_duty = '0;
    run_ms = '0;
    hold_count = '0;
    dir_latch = 1'b0;
    last_pos = gmss_pkg::POS_UNKNOWN;
    motor_on = 1'b0;
    foreach (adc_window[i]) adc_window[i] = '0;
    window_ptr = '0;
  endfunction

  function automatic gmss_pkg::res_t advance_gate(input logic [1:0] func,
                                                  input logic [gmss_pkg::SAMPLE_W-1:0] sample,
                                                  input logic dir);
    gmss_pkg::res_t r;
    logic [gmss_pkg::MS_W:0] ms_sum;
    int unsigned over;
    logic fin;
    logic trip;
    logic tout;
    fin = 1'b0;
    trip = 1'b0;
    tout = 1'b0;
    case (func)
      gmss_pkg::FUNC_TICK: begin
        case (gate_phase)
          gmss_pkg::PH_INIT: begin
            run_ms = '0;
            motor_on = 1'b1;
            gate_duty = '0;
            hold_count = gmss_pkg::DELAY_W'(gmss_pkg::RELAY_TICKS);
            gate_phase = gmss_pkg::PH_RELAY;
          end
          gmss_pkg::PH_RELAY: begin
            if (hold_count > 0) begin
              hold_count = hold_count - 1'b1;
            end else begin
              gate_duty = shadow_cfg.start_duty;
              gate_phase = gmss_pkg::PH_RAMP;
            end
          end
          gmss_pkg::PH_RAMP: begin
            if (gate_duty < shadow_cfg.full_duty) gate_duty = gate_duty + 1'b1;
            else gate_phase = gmss_pkg::PH_RUN;
          end
          gmss_pkg::PH_RUN: begin
            if (run_ms > shadow_cfg.slowdown_after_ms) gate_phase = gmss_pkg::PH_SLOW;
          end
          gmss_pkg::PH_SLOW: begin
            if (gate_duty > shadow_cfg.creep_duty) begin
              gate_duty = (gate_duty >= gmss_pkg::DUTY_W'(gmss_pkg::SLOW_STEP)) ?
                          gate_duty - gmss_pkg::DUTY_W'(gmss_pkg::SLOW_STEP) : '0;
            end else begin
              gate_duty = shadow_cfg.creep_duty;
              gate_phase = gmss_pkg::PH_LOW;
            end
          end
          gmss_pkg::PH_TOZERO: begin
            if (gate_duty >= gmss_pkg::DUTY_W'(gmss_pkg::STOP_STEP)) begin
              gate_duty = gate_duty - gmss_pkg::DUTY_W'(gmss_pkg::STOP_STEP);
            end else begin
              gate_duty = '0;
              hold_count = gmss_pkg::DELAY_W'(gmss_pkg::WAIT_TICKS);
              gate_phase = gmss_pkg::PH_WAIT;
            end
          end
          gmss_pkg::PH_WAIT: begin
            if (hold_count > 0) hold_count = hold_count - 1'b1;
            else gate_phase = gmss_pkg::PH_END;
          end
          gmss_pkg::PH_END: begin
            motor_on = 1'b0;
            gate_phase = gmss_pkg::PH_STOP;
            last_pos = dir_latch ? gmss_pkg::AT_CLOSED : gmss_pkg::AT_OPEN;
            fin = 1'b1;
          end
          default: ;
        endcase
        if (motor_on) begin
          ms_sum = {1'b0, run_ms} + (gmss_pkg::MS_W + 1)'(gmss_pkg::TICK_MS);
          run_ms = ms_sum[gmss_pkg::MS_W] ? '1 : ms_sum[gmss_pkg::MS_W-1:0];
          if (run_ms > shadow_cfg.run_limit_ms) begin
            run_ms = '0;
            gate_phase = gmss_pkg::PH_TOZERO;
            tout = 1'b1;
          end
        end
      end
      gmss_pkg::FUNC_SAMPLE: begin
        if (run_ms > gmss_pkg::SAMPLE_AFTER_MS) begin
          adc_window[window_ptr] = sample;
          window_ptr = (window_ptr == WPTR_W'(gmss_pkg::WINDOW_LEN_DEF - 1)) ?
                       '0 : window_ptr + 1'b1;
          over = 0;
          foreach (adc_window[i]) if (adc_window[i] > shadow_cfg.trip_level) over++;
          if (motor_on && over >= gmss_pkg::TRIP_COUNT) begin
            gate_duty = '0;
            motor_on = 1'b0;
            gate_phase = gmss_pkg::PH_END;
            trip = 1'b1;
          end
        end
      end
      gmss_pkg::FUNC_START: begin
        dir_latch = dir;
        gate_phase = gmss_pkg::PH_INIT;
      end
      default: ;
    endcase
    r.pwm_duty = gate_duty;
    r.phase = gate_phase;
    r.running = motor_on;
    r.position = last_pos;
    r.finished = fin;
    r.tripped = trip;
    r.timed_out = tout;
    return r;
  endfunction

  function automatic logic [gmss_pkg::SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(0, 1) && shadow_cfg.trip_level < 10'h3FF)
      return gmss_pkg::SAMPLE_W'($urandom_range(shadow_cfg.trip_level + 1, 1023));
    return gmss_pkg::SAMPLE_W'($urandom_range(0, 1023));
  endfunction

  function automatic gmss_pkg::cfg_t pick_settings(input bit trip_prone);
    gmss_pkg::cfg_t c;
    c.start_duty = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) c.full_duty = 8'($urandom_range(0, 255));
    else if (c.start_duty > 8'd243) c.full_duty = 8'd255;
    else c.full_duty = c.start_duty + 8'($urandom_range(0, 12));
    c.creep_duty = 8'($urandom_range(0, 255));
    c.slowdown_after_ms = 16'($urandom_range(0, 400));
    c.run_limit_ms = trip_prone ? 16'($urandom_range(2050, 2600)) : 16'($urandom_range(0, 700));
    c.trip_level = 10'($urandom_range(0, 1023));
    return c;
  endfunction

  task automatic push_item(input logic [1:0] func,
                           input logic [gmss_pkg::SAMPLE_W-1:0] sample,
                           input logic dir);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, dir, sample};
    s_axis_tuser <= func;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(advance_gate(func, sample, dir));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input gmss_pkg::cfg_idx_t idx,
                           input logic [gmss_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gmss_pkg::CFG_START_DUTY: shadow_cfg.start_duty = value[gmss_pkg::DUTY_W-1:0];
      gmss_pkg::CFG_FULL_DUTY: shadow_cfg.full_duty = value[gmss_pkg::DUTY_W-1:0];
      gmss_pkg::CFG_CREEP_DUTY: shadow_cfg.creep_duty = value[gmss_pkg::DUTY_W-1:0];
      gmss_pkg::CFG_SLOWDOWN: shadow_cfg.slowdown_after_ms = value;
      gmss_pkg::CFG_RUN_LIMIT: shadow_cfg.run_limit_ms = value;
      gmss_pkg::CFG_TRIP_LEVEL: shadow_cfg.trip_level = value[gmss_pkg::SAMPLE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // hold until the pipe is empty, then load all six registers
  task automatic apply_config(input gmss_pkg::cfg_t c);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    write_reg(gmss_pkg::CFG_START_DUTY, {8'($urandom), c.start_duty});
    write_reg(gmss_pkg::CFG_FULL_DUTY, {8'($urandom), c.full_duty});
    write_reg(gmss_pkg::CFG_CREEP_DUTY, {8'($urandom), c.creep_duty});
    write_reg(gmss_pkg::CFG_SLOWDOWN, c.slowdown_after_ms);
    write_reg(gmss_pkg::CFG_RUN_LIMIT, c.run_limit_ms);
    write_reg(gmss_pkg::CFG_TRIP_LEVEL, {6'($urandom), c.trip_level});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_basics();
    push_item(FUNC_UNUSED, 10'h3FF, 1'b1);
    push_item(gmss_pkg::FUNC_SAMPLE, 10'h000, 1'b0);
    push_item(gmss_pkg::FUNC_SAMPLE, 10'h3FF, 1'b1);
    push_item(gmss_pkg::FUNC_TICK, 10'h2AA, 1'b0);
    push_item(gmss_pkg::FUNC_START, 10'h155, 1'b1);
    push_item(gmss_pkg::FUNC_TICK, 10'h000, 1'b0);
    push_item(gmss_pkg::FUNC_START, 10'h3FF, 1'b0);
    repeat (6) push_item(gmss_pkg::FUNC_TICK, 10'($urandom), 1'($urandom));
    push_item(FUNC_UNUSED, 10'h000, 1'b0);
    push_item(gmss_pkg::FUNC_SAMPLE, 10'h200, 1'b0);
  endtask

  // odd duty with creep at zero takes the slow-down step past zero, where it clamps
  task automatic test_directed_edges();
    apply_config('{8'd1, 8'd1, 8'd0, 16'd0, 16'hFFFF, 10'h3FF});
    push_item(gmss_pkg::FUNC_START, 10'($urandom), 1'b0);
    repeat (11) push_item(gmss_pkg::FUNC_TICK, 10'($urandom), 1'($urandom));
  endtask

  task automatic test_random_runs(input gmss_pkg::cfg_t c, input int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    int unsigned pick;
    apply_config(c);
    sent = 0;
    while (sent < n_items) begin
      push_item(gmss_pkg::FUNC_START, 10'($urandom), 1'($urandom));
      sent++;
      run_len = $urandom_range(30, 600);
      for (int unsigned k = 0;
           k < run_len && sent < n_items && gate_phase != gmss_pkg::PH_STOP; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) push_item(gmss_pkg::FUNC_TICK, 10'($urandom), 1'($urandom));
        else if (pick < 96) push_item(gmss_pkg::FUNC_SAMPLE, pick_sample(), 1'($urandom));
        else if (pick < 98) push_item(FUNC_UNUSED, 10'($urandom), 1'($urandom));
        else push_item(gmss_pkg::FUNC_START, 10'($urandom), 1'($urandom));
        sent++;
      end
      repeat ($urandom_range(0, 4)) begin
        push_item($urandom_range(0, 1) ? gmss_pkg::FUNC_TICK : gmss_pkg::FUNC_SAMPLE,
                  pick_sample(), 1'($urandom));
        sent++;
      end
    end
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_res = gmss_pkg::res_t'(m_axis_tdata[$bits(gmss_pkg::res_t)-1:0]);
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata);
      end else begin
        want_res = pending_results.pop_front();
        check_field("pwm_duty", 16'(want_res.pwm_duty), 16'(got_res.pwm_duty));
        check_field("phase", 16'(want_res.phase), 16'(got_res.phase));
        check_field("running", 16'(want_res.running), 16'(got_res.running));
        check_field("position", 16'(want_res.position), 16'(got_res.position));
        check_field("finished", 16'(want_res.finished), 16'(got_res.finished));
        check_field("tripped", 16'(want_res.tripped), 16'(got_res.tripped));
        check_field("timed_out", 16'(want_res.timed_out), 16'(got_res.timed_out));
        results_seen++;
        if (got_res.tripped === 1'b1) trips_seen++;
        if (got_res.timed_out === 1'b1) timeouts_seen++;
        if (got_res.finished === 1'b1) runs_finished++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    reset_gate();
    send_gap_pct = 25;
    sink_stall_pct = 69;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_directed_edges();
    test_random_runs(pick_settings(1'b1), 100);
    test_random_runs(pick_settings(1'b0), 70);

    send_gap_pct = 69;
    sink_stall_pct = 25;
    test_random_runs('0, 40);
    test_random_runs(pick_settings(1'b1), 100);
    test_random_runs(pick_settings(1'b0), 70);

    send_gap_pct = 0;
    sink_stall_pct = 0;
    test_random_runs(pick_settings(1'b1), 100);
    test_random_runs(pick_settings(1'b0), 70);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Sent %0d items and checked %0d results across several register settings.",
             items_sent, results_seen);
    $display("Saw %0d completed runs, %0d overcurrent trips, %0d run-time limit stops.",
             runs_finished, trips_seen, timeouts_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
